### src/bdf_pkg.sv
// ----------------------------------------------------------------------------
// bdf_pkg
// Shared types and constants of the battery derate factor unit: widths,
// fixed-point limits, reciprocal constants and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bdf_pkg;

    // widths
    localparam int FRAC_BITS = 16;
    localparam int SAMPLE_W  = 16;
    localparam int ACC_W     = SAMPLE_W + FRAC_BITS;
    localparam int ALPHA_W   = 16;
    localparam int FACTOR_W  = 16;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int N_W       = 28;
    localparam int Q_W       = 15;
    localparam int IN_W      = 2 * SAMPLE_W;
    localparam int OUT_W     = FACTOR_W + 2 * SAMPLE_W;
    localparam int CFG_IDX_W = 8;

    // lanes
    localparam int NUM_LANES = 2;
    localparam int LANE_V    = 0;
    localparam int LANE_T    = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_ALPHA = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_ALPHA    = CFG_IDX_W'(1);
    localparam logic [ALPHA_W-1:0]   ALPHA_RESET       = ALPHA_W'(58982);
    localparam logic [ALPHA_W:0]     ALPHA_ONE         = (ALPHA_W+1)'(1) << ALPHA_W;

    // factor limits, Q1.15
    localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(32768);
    localparam logic [FACTOR_W-1:0] FACTOR_MIN = FACTOR_W'(6554);
    localparam longint DROP_MAX = 32768 - 6554;

    // filter rounding and temperature offset
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (ALPHA_W - 1);
    localparam logic [ACC_W-1:0] T_BIAS     = ACC_W'(32768) << FRAC_BITS;
    localparam logic [SAMPLE_W-1:0] SIGN_FLIP = SAMPLE_W'(32768);

    // map break points in accumulator units (temperature in offset binary)
    localparam logic [ACC_W-1:0] V_TOP = ACC_W'(35000) << FRAC_BITS;
    localparam logic [ACC_W-1:0] T_BOT = ACC_W'(5000 + 32768) << FRAC_BITS;

    // drop = floor((d + DIV/2) / DIV) after removing common powers of two
    localparam longint DIV_V = longint'(1875) << (FRAC_BITS - 14);
    localparam longint DIV_T = longint'(125) << (FRAC_BITS - 12);
    localparam longint HALF_V = DIV_V / 2;
    localparam longint HALF_T = DIV_T / 2;
    localparam longint LIM_V = (DROP_MAX + 1) * DIV_V;
    localparam longint LIM_T = (DROP_MAX + 1) * DIV_T;

    // reciprocals, q0 = (n * RCP) >> SHIFT is exact or one low
    localparam int RCP_SHIFT_V = 42;
    localparam int RCP_SHIFT_T = 40;
    localparam longint RCP_V = (longint'(1) << RCP_SHIFT_V) / DIV_V;
    localparam longint RCP_T = (longint'(1) << RCP_SHIFT_T) / DIV_T;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul_old;
        logic mul_new;
        logic update;
        logic prep;
        logic mul_rcp;
        logic mul_back;
        logic fix;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

### src/bdf_ctrl.sv
// ----------------------------------------------------------------------------
// bdf_ctrl
// Sequencer of the derate unit: steps one item through filter update,
// factor mapping and hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdf_ctrl
    import bdf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_MUL_OLD  = 9'b000000010,
        ST_MUL_NEW  = 9'b000000100,
        ST_UPDATE   = 9'b000001000,
        ST_PREP     = 9'b000010000,
        ST_MUL_RCP  = 9'b000100000,
        ST_MUL_BACK = 9'b001000000,
        ST_FIX      = 9'b010000000,
        ST_OUT      = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL_OLD;
                end
            end
            ST_MUL_OLD:
            begin
                cmd.mul_old = 1'b1;
                state_next  = ST_MUL_NEW;
            end
            ST_MUL_NEW:
            begin
                cmd.mul_new = 1'b1;
                state_next  = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_MUL_RCP;
            end
            ST_MUL_RCP:
            begin
                cmd.mul_rcp = 1'b1;
                state_next  = ST_MUL_BACK;
            end
            ST_MUL_BACK:
            begin
                cmd.mul_back = 1'b1;
                state_next   = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### src/bdf_datapath.sv
// ----------------------------------------------------------------------------
// bdf_datapath
// Two lanes (voltage, temperature), each with an EMA accumulator, one
// 32x32 multiplier and a reciprocal divider; plus config and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bdf_datapath
    import bdf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_cmd_t              cmd,
    output dp_sts_t                   sts,
    input  wire logic [SAMPLE_W-1:0]  in_voltage,
    input  wire logic [SAMPLE_W-1:0]  in_temp,
    input  wire logic                 cfg_wr,
    input  wire logic [CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [ALPHA_W-1:0]   cfg_val,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [OUT_W-1:0]          out_data
);

    logic [ALPHA_W-1:0]  alpha_reg [NUM_LANES];
    logic [FACTOR_W-1:0] fac_reg   [NUM_LANES];
    logic [ACC_W-1:0]    acc_reg   [NUM_LANES];
    logic [SAMPLE_W-1:0] x_in      [NUM_LANES];

    logic                out_valid_reg;
    logic [OUT_W-1:0]    out_data_reg;
    logic [FACTOR_W-1:0] factor_min;

    // temperature runs in offset binary
    assign x_in[LANE_V] = in_voltage;
    assign x_in[LANE_T] = in_temp ^ SIGN_FLIP;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg[LANE_V] <= ALPHA_RESET;
            alpha_reg[LANE_T] <= ALPHA_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                CFG_VOLTAGE_ALPHA: alpha_reg[LANE_V] <= cfg_val;
                CFG_TEMP_ALPHA:    alpha_reg[LANE_T] <= cfg_val;
                default:           ;
            endcase
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        localparam logic [ACC_W-1:0] ACC_INIT = (l == LANE_V) ? '0 : T_BIAS;
        localparam int               SHIFT    = (l == LANE_V) ? RCP_SHIFT_V : RCP_SHIFT_T;
        localparam logic [MUL_W-1:0] RCP      = MUL_W'((l == LANE_V) ? RCP_V : RCP_T);
        localparam logic [MUL_W-1:0] DIV      = MUL_W'((l == LANE_V) ? DIV_V : DIV_T);
        localparam logic [ACC_W:0]   HALF     = (ACC_W+1)'((l == LANE_V) ? HALF_V : HALF_T);
        localparam logic [ACC_W:0]   LIM      = (ACC_W+1)'((l == LANE_V) ? LIM_V : LIM_T);

        logic [SAMPLE_W-1:0] x_reg;
        logic [PROD_W-1:0]   prod_reg;
        logic [ACC_W-1:0]    part_reg;
        logic [N_W-1:0]      n_reg;
        logic [Q_W-1:0]      q_reg;
        logic                pass_reg;
        logic                clamp_reg;

        logic [MUL_W-1:0]    mul_a;
        logic [MUL_W-1:0]    mul_b;
        logic [Q_W-1:0]      q_est;
        logic [ACC_W:0]      acc_sum;
        logic                pass;
        logic [ACC_W-1:0]    span;
        logic [ACC_W:0]      n_full;
        logic [N_W-1:0]      rem;
        logic [Q_W-1:0]      drop;

        assign q_est = prod_reg[SHIFT +: Q_W];

        // multiplier operand select
        always_comb
        begin
            mul_a = '0;
            mul_b = '0;
            priority if (cmd.mul_old)
            begin
                mul_a = MUL_W'(alpha_reg[l]);
                mul_b = MUL_W'(acc_reg[l]);
            end
            else if (cmd.mul_new)
            begin
                mul_a = MUL_W'(ALPHA_ONE - {1'b0, alpha_reg[l]});
                mul_b = MUL_W'(x_reg);
            end
            else if (cmd.mul_rcp)
            begin
                mul_a = RCP;
                mul_b = MUL_W'(n_reg);
            end
            else
            begin
                mul_a = DIV;
                mul_b = MUL_W'(q_est);
            end
        end

        // new weight term is a multiple of 2^16, so rounding applies to the old term only
        assign acc_sum = {1'b0, part_reg} + (ACC_W+1)'(prod_reg[ACC_W:0]);

        // distance past the break point
        always_comb
        begin
            if (l == LANE_V)
            begin
                pass = (acc_reg[l] >= V_TOP);
                span = V_TOP - acc_reg[l];
            end
            else
            begin
                pass = (acc_reg[l] <= T_BOT);
                span = acc_reg[l] - T_BOT;
            end
        end

        assign n_full = {1'b0, span} + HALF;

        // one-step correction of the reciprocal quotient
        assign rem  = n_reg - prod_reg[N_W-1:0];
        assign drop = q_reg + Q_W'(rem >= DIV[N_W-1:0]);

        // filter state
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                acc_reg[l] <= ACC_INIT;
            end
            else if (cmd.update)
            begin
                acc_reg[l] <= acc_sum[ACC_W-1:0];
            end
        end

        // working registers
        always_ff @(posedge clk)
        begin
            if (cmd.load)
            begin
                x_reg <= x_in[l];
            end
            if (cmd.mul_old || cmd.mul_new || cmd.mul_rcp || cmd.mul_back)
            begin
                prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
            end
            if (cmd.mul_new)
            begin
                part_reg <= ACC_W'((prod_reg + PROD_W'(ROUND_HALF)) >> ALPHA_W);
            end
            if (cmd.prep)
            begin
                pass_reg  <= pass;
                clamp_reg <= (n_full >= LIM);
                n_reg     <= n_full[N_W-1:0];
            end
            if (cmd.mul_back)
            begin
                q_reg <= q_est;
            end
            if (cmd.fix)
            begin
                if (pass_reg)
                begin
                    fac_reg[l] <= FACTOR_ONE;
                end
                else if (clamp_reg)
                begin
                    fac_reg[l] <= FACTOR_MIN;
                end
                else
                begin
                    fac_reg[l] <= FACTOR_ONE - FACTOR_W'(drop);
                end
            end
        end
    end

    assign factor_min = (fac_reg[LANE_V] < fac_reg[LANE_T]) ? fac_reg[LANE_V]
                                                           : fac_reg[LANE_T];

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register data
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {acc_reg[LANE_T][ACC_W-1 -: SAMPLE_W] ^ SIGN_FLIP,
                             acc_reg[LANE_V][ACC_W-1 -: SAMPLE_W],
                             factor_min};
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

endmodule

`default_nettype wire

### src/battery_derate_factor_unit.sv
// ----------------------------------------------------------------------------
// battery_derate_factor_unit
// Filters cell voltage and temperature readings and maps both onto a
// current derate factor in Q1.15, reporting the smaller one.
//
//  channel   dir  handshake            beat contents
//  s_*       in   s_tvalid/s_tready    low_voltage_raw, high_temp_raw
//  m_*       out  m_tvalid/m_tready    derate_factor, filtered_voltage, filtered_temp
//  cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data (alpha registers)
//
// from input beat to output valid, an item runs through the steps of the
// sequencer: two filter multiplies, update, prep, reciprocal multiply,
// back-multiply, correction and output load on one multiplier per lane.
// a new input beat is taken the cycle after the output register is loaded.
// if the output register still holds an untaken result, the item waits
// in its last step; cfg_ready is always high.
// reset clears the filters and loads the default alphas.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_derate_factor_unit
    import bdf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_W-1:0]      s_tdata,   // low_voltage_raw, high_temp_raw
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_W-1:0]          m_tdata,   // derate_factor, filtered_voltage, filtered_temp
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ALPHA_W-1:0]   cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    // sequencer
    bdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic
    bdf_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_voltage (s_tdata[SAMPLE_W-1:0]),
        .in_temp    (s_tdata[IN_W-1 -: SAMPLE_W]),
        .cfg_wr     (cfg_valid && cfg_ready),
        .cfg_idx    (cfg_index),
        .cfg_val    (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata)
    );

endmodule

`default_nettype wire

### src/bdf_checker.sv
// ----------------------------------------------------------------------------
// bdf_checker
// Port-level checks of the derate unit: output hold, factor range,
// one item in flight and fixed latency to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module bdf_checker
    import bdf_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [OUT_W-1:0]     m_tdata
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // factor stays within 0.2 .. 1.0
    a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[FACTOR_W-1:0] >= FACTOR_MIN) &&
                     (m_tdata[FACTOR_W-1:0] <= FACTOR_ONE))
        else $error("derate factor out of range");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // a fresh result appears a fixed time after its input beat
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 9))
        else $error("output valid without matching input beat");

endmodule

bind battery_derate_factor_unit bdf_checker u_bdf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks battery_derate_factor_unit beat by beat. A scoreboard class keeps
// its own copy of both exponential filters and the two alpha registers,
// predicts factor, filtered voltage and filtered temperature for every
// accepted input beat, and compares each output beat in order. Directed
// readings hit the map corners and clamps; random phases drive sustained
// runs of readings near the derating windows under several alpha settings,
// with random gaps and stalls on both streams and one long output stall.
// ----------------------------------------------------------------------------

module testbench;
    import bdf_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 3000;

    // one expected output beat
    typedef struct {
        logic [15:0] factor;
        logic [15:0] volts;
        logic [15:0] temp;
    } derate_result_t;

    // filter and map predictor plus the store of pending results
    class derate_scoreboard;
        localparam longint unsigned ONE_Q15   = 32768;
        localparam longint unsigned MIN_Q15   = 6554;
        localparam longint unsigned DROP_CAP  = 32768 - 6554;
        localparam longint unsigned WINDOW_V  = longint'(35000) << 16;
        localparam longint unsigned WINDOW_T  = longint'(5000 + 32768) << 16;
        localparam longint unsigned T_OFFSET  = longint'(32768) << 16;

        longint unsigned v_alpha;
        longint unsigned t_alpha;
        longint unsigned v_acc;
        longint unsigned t_acc_off;
        derate_result_t  pending_results[$];
        int              fails;

        function new();
            v_alpha   = 58982;
            t_alpha   = 58982;
            v_acc     = 0;
            t_acc_off = T_OFFSET;
            fails     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ALPHA_W-1:0] value);
            if (idx == CFG_VOLTAGE_ALPHA)
                v_alpha = value;
            else if (idx == CFG_TEMP_ALPHA)
                t_alpha = value;
        endfunction

        function longint unsigned filter_step(longint unsigned alpha, longint unsigned acc,
                                              longint unsigned sample);
            longint unsigned sum;
            sum = alpha * acc + (65536 - alpha) * (sample << 16);
            return (sum + 32768) >> 16;
        endfunction

        function longint unsigned drop_to_factor(longint unsigned drop);
            return (drop > DROP_CAP) ? MIN_Q15 : ONE_Q15 - drop;
        endfunction

        // advance both filters on an accepted reading and queue the result
        function void take_reading(logic [15:0] v_raw, logic [15:0] t_raw);
            longint unsigned d;
            longint unsigned den;
            longint unsigned v_factor;
            longint unsigned t_factor;
            longint unsigned factor;
            derate_result_t  res;
            v_acc     = filter_step(v_alpha, v_acc, longint'(v_raw));
            t_acc_off = filter_step(t_alpha, t_acc_off, longint'(t_raw ^ 16'h8000));

            // voltage: full factor at or above 3.5 V
            if (v_acc >= WINDOW_V) begin
                v_factor = ONE_Q15;
            end
            else begin
                d        = WINDOW_V - v_acc;
                den      = longint'(1875) << 16;
                v_factor = drop_to_factor((d * 16384 + den / 2) / den);
            end

            // temperature: full factor at or below 50 degC
            if (t_acc_off <= WINDOW_T) begin
                t_factor = ONE_Q15;
            end
            else begin
                d        = t_acc_off - WINDOW_T;
                den      = longint'(125) << 16;
                t_factor = drop_to_factor((d * 4096 + den / 2) / den);
            end

            factor     = (v_factor < t_factor) ? v_factor : t_factor;
            res.factor = factor[15:0];
            res.volts  = v_acc[31:16];
            res.temp   = t_acc_off[31:16] ^ 16'h8000;
            pending_results.push_back(res);
        endfunction

        // compare one output beat with the oldest pending result
        function void check_beat(logic [OUT_W-1:0] beat);
            derate_result_t res;
            if (pending_results.size() == 0) begin
                $error("output beat 0x%012h with no result pending", beat);
                fails++;
                return;
            end
            res = pending_results.pop_front();
            if (beat[15:0] !== res.factor) begin
                $error("derate_factor expected %0d got %0d", res.factor, beat[15:0]);
                fails++;
            end
            if (beat[31:16] !== res.volts) begin
                $error("filtered_voltage expected %0d got %0d", res.volts, beat[31:16]);
                fails++;
            end
            if (beat[47:32] !== res.temp) begin
                $error("filtered_temp expected %0d got %0d",
                       $signed(res.temp), $signed(beat[47:32]));
                fails++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata   = '0;   // low_voltage_raw, high_temp_raw
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_W-1:0]     m_tdata;          // derate_factor, filtered_voltage, filtered_temp
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ALPHA_W-1:0]   cfg_data  = '0;

    derate_scoreboard sb = new();
    bit send_idle   = 1'b1;
    bit recv_idle   = 1'b1;
    bit hold_output = 1'b0;
    int stall_count = 0;

    battery_derate_factor_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // one register write beat, with the channel left idle after it
    task automatic write_alpha(logic [CFG_IDX_W-1:0] idx, logic [ALPHA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_alphas(logic [ALPHA_W-1:0] va, logic [ALPHA_W-1:0] ta);
        write_alpha(CFG_VOLTAGE_ALPHA, va);
        write_alpha(CFG_TEMP_ALPHA, ta);
    endtask

    // offer one reading beat after a random gap
    task automatic send_reading(logic [15:0] v_raw, logic [15:0] t_raw);
        int gap;
        gap = send_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t_raw, v_raw};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.take_reading(v_raw, t_raw);
    endtask

    // stop offering and wait until every pending result has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // output side: random ready gaps, one long hold when asked
    task automatic accept_results();
        int gap;
        forever begin
            gap = recv_idle ? $urandom_range(0, 7) : 0;
            if (gap > 0 || hold_output)
                m_tready <= 1'b0;
            if (hold_output) begin
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            repeat (gap) @(posedge clk);
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            sb.check_beat(m_tdata);
        end
    endtask

    // voltage target: mostly inside or near the 3.2..3.5 V window
    function automatic logic [15:0] pick_voltage();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 16'(31500 + $urandom_range(0, 4000));
            5, 6:          return 16'($urandom());
            7:             return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            8:             return 16'(29000 + $urandom_range(0, 9000));
            default:       return 16'(34990 + $urandom_range(0, 20));
        endcase
    endfunction

    // temperature target: mostly inside or near the 50..58 degC window
    function automatic logic [15:0] pick_temp();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 16'(4700 + $urandom_range(0, 1400));
            5, 6:          return 16'($urandom());
            7:             return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            8:             return 16'($urandom_range(0, 8000) - 2000);
            default:       return 16'(4990 + $urandom_range(0, 20));
        endcase
    endfunction

    // sustained runs around a target so the filters settle, plus noise beats
    task automatic run_readings(int count);
        logic [15:0] v_target;
        logic [15:0] t_target;
        int          run_len;
        int          sent;
        sent = 0;
        while (sent < count) begin
            v_target = pick_voltage();
            t_target = pick_temp();
            run_len  = $urandom_range(1, 24);
            for (int i = 0; i < run_len && sent < count; i++) begin
                if ($urandom_range(0, 7) == 0)
                    send_reading(16'($urandom()), 16'($urandom()));
                else
                    send_reading(16'(int'(v_target) + $urandom_range(0, 64) - 32),
                                 16'(int'(t_target) + $urandom_range(0, 64) - 32));
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            accept_results();
        join_none

        // default alphas from reset, corners of both fields
        send_reading(16'h0000, 16'h8000);
        send_reading(16'hFFFF, 16'h7FFF);
        send_reading(16'd35000, 16'd5000);
        send_reading(16'd33000, 16'd5400);
        wait_drained();

        // no filtering, plus writes to indexes past the two registers
        set_alphas(16'h0000, 16'h0000);
        write_alpha(CFG_IDX_W'($urandom_range(2, 254)), 16'($urandom()));
        write_alpha({CFG_IDX_W{1'b1}}, 16'hFFFF);
        send_reading(16'hFFFF, 16'h8000);     // above 3.5 V, below 50 degC
        send_reading(16'd35000, 16'd5000);    // exactly on the full-factor edge
        send_reading(16'd34999, 16'd5001);
        send_reading(16'd32000, 16'd5800);    // exactly at the floor
        send_reading(16'd31999, 16'd5801);    // past the floor, clamped
        send_reading(16'h0000, 16'h7FFF);
        send_reading(16'd33500, 16'd5000);
        send_reading(16'd35000, 16'd5400);
        send_reading(16'd33000, 16'd5200);
        send_reading(16'd34000, 16'd5700);
        send_reading(16'h5555, 16'h5555);
        send_reading(16'hAAAA, 16'hAAAA);
        send_reading(16'd36000, 16'hFF9C);    // negative temperature
        send_reading(16'd32600, 16'd5600);
        wait_drained();

        // slowest filters
        set_alphas(16'hFFFF, 16'hFFFF);
        run_readings(60);
        wait_drained();

        // long output hold while the input keeps offering back to back
        set_alphas(16'h0000, 16'h0000);
        send_idle   = 1'b0;
        hold_output = 1'b1;
        run_readings(120);
        wait_drained();

        // default alphas, gaps on both sides
        send_idle = 1'b1;
        set_alphas(16'd58982, 16'd58982);
        run_readings(150);
        wait_drained();

        // random alphas, sender steady, receiver gapped
        send_idle = 1'b0;
        set_alphas(16'($urandom()), 16'($urandom()));
        run_readings(150);
        wait_drained();

        // random alphas, sender gapped, receiver steady
        send_idle = 1'b1;
        recv_idle = 1'b0;
        set_alphas(16'($urandom_range(0, 65535)), 16'($urandom_range(60000, 65535)));
        run_readings(150);
        wait_drained();

        // one filter open, the other half weight, no gaps
        send_idle = 1'b0;
        set_alphas(16'h8000, 16'h0000);
        run_readings(150);
        wait_drained();

        if (sb.pending() != 0) begin
            $error("%0d results never arrived", sb.pending());
            sb.fails++;
        end
        if (sb.fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
